// ----- sv/lifneu_pkg.sv -----
// Shared types, constants and table functions of the LIF neuron event update block.
`default_nettype none
package lifneu_pkg;

	localparam int NEURONS_DEFAULT = 1024;
	localparam int TABLE_SIZE_DEFAULT = 1024;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_MEM_TAU = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SYN_TAU = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_LEVEL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE = 3'd6;

	localparam logic [31:0] STOP_TIME_RST = 32'hFFFF_FFFF;
	localparam logic [31:0] REFRACTORY_RST = 32'd131072;
	localparam logic [23:0] INV_MEM_TAU_RST = 24'd3277;
	localparam logic [23:0] INV_SYN_TAU_RST = 24'd13107;
	localparam logic signed [31:0] REST_LEVEL_RST = 32'sd0;
	localparam logic signed [31:0] FIRE_LEVEL_RST = 32'sd1310720;
	localparam logic [31:0] RESISTANCE_RST = 32'd65536;

	// datapath latency from accept to commit, in cycles spent in the busy state
	localparam int BUSY_CYCLES = 8;
	localparam int BUSY_CNT_W = 3;

	typedef struct packed {
		logic signed [31:0] cur;
		logic [31:0] cur_time;
		logic signed [31:0] volt;
		logic [31:0] volt_time;
		logic [31:0] spike_time;
		logic never;
		logic [31:0] count;
	} row_t;

	localparam row_t ROW_CLEAR = '{never: 1'b1, default: '0};

	typedef struct packed {
		logic clear;
		logic load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [63:0] exp_neg_q31(input logic [63:0] y);
		logic signed [63:0] sum;
		logic [63:0] mag;
		sum = 64'sd2147483648;
		mag = 64'd2147483648;
		for (int n = 1; n <= 14; n++) begin
			mag = ((mag * y) >> 31) / 64'(n);
			if ((n & 1) != 0) sum = sum - $signed(mag);
			else sum = sum + $signed(mag);
		end
		if (sum < 0) sum = '0;
		return $unsigned(sum);
	endfunction

endpackage
`default_nettype wire

// ----- sv/lif_neuron_event_update.sv -----
// Top level of the event-driven LIF neuron update with exponential synapse.
`default_nettype none
// Takes one synaptic event per word and returns one result word per event. After reset
// a clearing pass writes the per-neuron state memory one neuron a cycle (all NEURONS
// rows, 1024 by default) before the first event is taken. Each event then passes from
// accept to result through one state memory read, seven arithmetic stages (two decay
// table lookups and a chain of three dependent multiplies), and a write-back of the
// neuron's state that loads the result register in the same cycle. The next event is
// taken in the cycle after write-back, so events do not overlap and events on the same
// neuron may follow each other. The result sits in an output register, so the next
// event is accepted while it waits; a result still waiting at write-back time holds the
// current event until it is taken.
// Configuration writes take effect at once and are meant for idle periods.
module lif_neuron_event_update #(
	parameter int NEURONS = lifneu_pkg::NEURONS_DEFAULT,
	parameter int DECAY_TABLE_SIZE = lifneu_pkg::TABLE_SIZE_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [lifneu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [9:0] neuron_index,
	input  wire logic [31:0] event_time,
	input  wire logic signed [31:0] event_weight,
	output logic out_valid,
	input  wire logic out_ready,
	output logic fired,
	output logic dropped,
	output logic [9:0] spiking_neuron,
	output logic [31:0] spike_time,
	output logic signed [31:0] voltage_now,
	output logic [31:0] spike_total
);

	lifneu_pkg::cmd_t cmd;
	lifneu_pkg::sts_t sts;

	lifneu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.sts(sts)
	);

	lifneu_dp #(
		.NEURONS(NEURONS),
		.DECAY_TABLE_SIZE(DECAY_TABLE_SIZE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.neuron_index(neuron_index),
		.event_time(event_time),
		.event_weight(event_weight),
		.fired(fired),
		.dropped(dropped),
		.spiking_neuron(spiking_neuron),
		.spike_time(spike_time),
		.voltage_now(voltage_now),
		.spike_total(spike_total)
	);

endmodule
`default_nettype wire

// ----- sv/lifneu_ctrl.sv -----
// Sequencer of the LIF neuron update: clearing pass, accept, latency wait, commit.
`default_nettype none
module lifneu_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	output lifneu_pkg::cmd_t cmd,
	input  wire lifneu_pkg::sts_t sts
);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_BUSY, ST_FINISH} state_t;

	state_t state_q;
	logic [lifneu_pkg::BUSY_CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.clear = (state_q == ST_CLEAR);
	assign cmd.load = (state_q == ST_IDLE) && in_valid;
	assign cmd.commit = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_BUSY;
						cnt_q <= '0;
					end
				end
				ST_BUSY: begin
					if (cnt_q == lifneu_pkg::BUSY_CNT_W'(lifneu_pkg::BUSY_CYCLES - 1))
						state_q <= ST_FINISH;
					cnt_q <= cnt_q + 1'b1;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while busy");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed word not presented");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.clear_done |-> !in_ready)
		else $error("input taken during clearing pass");
	a_commit_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(state_q == ST_BUSY) || $past(state_q == ST_FINISH))
		else $error("commit without full latency");
`endif

endmodule
`default_nettype wire

// ----- sv/lifneu_dp.sv -----
// Datapath of the LIF neuron update: config registers, state memory, decay table, arithmetic.
`default_nettype none
module lifneu_dp #(
	parameter int NEURONS = lifneu_pkg::NEURONS_DEFAULT,
	parameter int DECAY_TABLE_SIZE = lifneu_pkg::TABLE_SIZE_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire lifneu_pkg::cmd_t cmd,
	output lifneu_pkg::sts_t sts,
	input  wire logic cfg_we,
	input  wire logic [lifneu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic [9:0] neuron_index,
	input  wire logic [31:0] event_time,
	input  wire logic signed [31:0] event_weight,
	output logic fired,
	output logic dropped,
	output logic [9:0] spiking_neuron,
	output logic [31:0] spike_time,
	output logic signed [31:0] voltage_now,
	output logic [31:0] spike_total
);

	localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int TW = $clog2(DECAY_TABLE_SIZE);
	localparam logic [63:0] H1 = (64'd8 << 31) / DECAY_TABLE_SIZE;
	localparam logic [63:0] H2 = (64'd16 << 31) / DECAY_TABLE_SIZE;

	typedef logic [15:0] rom_t [DECAY_TABLE_SIZE];

	function automatic rom_t build_rom();
		rom_t r;
		logic [63:0] v;
		logic [63:0] step;
		logic [63:0] e;
		step = lifneu_pkg::exp_neg_q31(H2);
		v = lifneu_pkg::exp_neg_q31(H1);
		for (int k = 0; k < DECAY_TABLE_SIZE; k++) begin
			e = (v + 64'd16384) >> 15;
			r[k] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
			v = (v * step + (64'd1 << 30)) >> 31;
		end
		return r;
	endfunction

	localparam rom_t DECAY_ROM = build_rom();

	logic [31:0] stop_q, refr_q, res_q;
	logic [23:0] inv_mem_q, inv_syn_q;
	logic signed [31:0] rest_q, fire_q;

	lifneu_pkg::row_t mem [NEURONS];
	lifneu_pkg::row_t row_s1;
	lifneu_pkg::row_t wr_row;
	logic [AW:0] clr_q;
	logic clearing;
	logic wr_en;
	logic [AW-1:0] wr_addr;

	logic [9:0] idx_q;
	logic [31:0] time_q;
	logic signed [31:0] weight_q;
	logic [AW-1:0] addr_q;
	logic drop_q;
	logic [AW+9:0] idx_ext;

	logic signed [32:0] dtc, dtv, dts;
	logic [55:0] pc_s2, pv_s2;
	logic pc_one_s2, pv_one_s2, outside_s2;
	logic [50:0] scaled_c, scaled_v;
	logic [15:0] rc_s3, rv_s3;
	logic c_one_s3, c_zero_s3, v_one_s3, v_zero_s3;
	logic [16:0] dc, dv;
	logic signed [49:0] cprod_s4;
	logic signed [31:0] cur_s5;
	logic signed [34:0] csum;
	logic signed [64:0] aprod_s6;
	logic signed [31:0] alpha_s7;
	logic signed [32:0] vdiff;
	logic signed [50:0] vprod_s8;
	logic signed [31:0] vnew;
	logic fire;
	logic [32:0] end_sum;
	logic [31:0] end_t;

	assign idx_ext = {{AW{1'b0}}, neuron_index};
	assign sts.clear_done = (clr_q == (AW+1)'(NEURONS));
	assign clearing = cmd.clear && !sts.clear_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= lifneu_pkg::STOP_TIME_RST;
			refr_q <= lifneu_pkg::REFRACTORY_RST;
			inv_mem_q <= lifneu_pkg::INV_MEM_TAU_RST;
			inv_syn_q <= lifneu_pkg::INV_SYN_TAU_RST;
			rest_q <= lifneu_pkg::REST_LEVEL_RST;
			fire_q <= lifneu_pkg::FIRE_LEVEL_RST;
			res_q <= lifneu_pkg::RESISTANCE_RST;
			clr_q <= '0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				case (cfg_index)
					lifneu_pkg::REG_STOP_TIME: stop_q <= cfg_data;
					lifneu_pkg::REG_REFRACTORY: refr_q <= cfg_data;
					lifneu_pkg::REG_INV_MEM_TAU: inv_mem_q <= cfg_data[23:0];
					lifneu_pkg::REG_INV_SYN_TAU: inv_syn_q <= cfg_data[23:0];
					lifneu_pkg::REG_REST_LEVEL: rest_q <= $signed(cfg_data);
					lifneu_pkg::REG_FIRE_LEVEL: fire_q <= $signed(cfg_data);
					lifneu_pkg::REG_RESISTANCE: res_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q <= neuron_index;
			time_q <= event_time;
			weight_q <= event_weight;
			addr_q <= idx_ext[AW-1:0];
			drop_q <= (event_time >= stop_q) || (32'(neuron_index) >= 32'(NEURONS));
		end
	end

	assign wr_en = clearing || (cmd.commit && !drop_q);
	assign wr_addr = clearing ? clr_q[AW-1:0] : addr_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= clearing ? lifneu_pkg::ROW_CLEAR : wr_row;
		row_s1 <= mem[addr_q];
	end

	assign dtc = $signed({1'b0, time_q}) - $signed({1'b0, row_s1.cur_time});
	assign dtv = $signed({1'b0, time_q}) - $signed({1'b0, row_s1.volt_time});
	assign dts = $signed({1'b0, time_q}) - $signed({1'b0, row_s1.spike_time});

	always_ff @(posedge clk) begin
		pc_s2 <= 56'(dtc[31:0]) * 56'(inv_syn_q);
		pv_s2 <= 56'(dtv[31:0]) * 56'(inv_mem_q);
		pc_one_s2 <= (dtc <= 33'sd0);
		pv_one_s2 <= (dtv <= 33'sd0);
		outside_s2 <= row_s1.never || (dts >= $signed({1'b0, refr_q}));
	end

	assign scaled_c = 51'(pc_s2[35:0]) * 51'(DECAY_TABLE_SIZE);
	assign scaled_v = 51'(pv_s2[35:0]) * 51'(DECAY_TABLE_SIZE);

	always_ff @(posedge clk) begin
		rc_s3 <= DECAY_ROM[scaled_c[36 +: TW]];
		rv_s3 <= DECAY_ROM[scaled_v[36 +: TW]];
		c_one_s3 <= pc_one_s2 || (pc_s2 == '0);
		v_one_s3 <= pv_one_s2 || (pv_s2 == '0);
		c_zero_s3 <= (pc_s2[55:36] != '0);
		v_zero_s3 <= (pv_s2[55:36] != '0);
	end

	assign dc = c_one_s3 ? 17'h10000 : (c_zero_s3 ? 17'd0 : {1'b0, rc_s3});
	assign dv = v_one_s3 ? 17'h10000 : (v_zero_s3 ? 17'd0 : {1'b0, rv_s3});

	assign csum = 35'(cprod_s4 >>> 16) + 35'(weight_q);
	assign vdiff = 33'(row_s1.volt) - 33'(alpha_s7);

	always_ff @(posedge clk) begin
		cprod_s4 <= row_s1.cur * $signed({1'b0, dc});
		cur_s5 <= lifneu_pkg::sat32(64'(csum));
		aprod_s6 <= cur_s5 * $signed({1'b0, res_q});
		alpha_s7 <= lifneu_pkg::sat32(64'(aprod_s6 >>> 16) + 64'(rest_q));
		vprod_s8 <= vdiff * $signed({1'b0, dv});
	end

	assign vnew = lifneu_pkg::sat32(64'(alpha_s7) + 64'(vprod_s8 >>> 16));
	assign fire = outside_s2 && (vnew >= fire_q);
	assign end_sum = {1'b0, time_q} + {1'b0, refr_q};
	assign end_t = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];

	always_comb begin
		wr_row = row_s1;
		wr_row.cur = cur_s5;
		wr_row.cur_time = time_q;
		if (outside_s2) begin
			wr_row.volt = fire ? rest_q : vnew;
			wr_row.volt_time = fire ? end_t : time_q;
		end
		if (fire) begin
			wr_row.spike_time = time_q;
			wr_row.never = 1'b0;
			if (row_s1.count != 32'hFFFF_FFFF) wr_row.count = row_s1.count + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			spiking_neuron <= idx_q;
			spike_time <= time_q;
			dropped <= drop_q;
			fired <= !drop_q && fire;
			voltage_now <= drop_q ? 32'sd0 : wr_row.volt;
			spike_total <= drop_q ? 32'd0 : wr_row.count;
		end
	end

endmodule
`default_nettype wire
